// ===== hw/rtl/cfvs_pkg.sv =====
// ----------------------------------------------------------------------------
// cfvs_pkg
// Shared types, codes and defaults of the call frame value stack.
// ----------------------------------------------------------------------------
package cfvs_pkg;

    localparam int VALUE_DEPTH_DEF    = 65536;
    localparam int FRAME_DEPTH_DEF    = 1024;
    localparam int CODE_ADDR_BITS_DEF = 32;

    typedef enum logic [3:0] {
        K_PUSH     = 4'd0,
        K_POP      = 4'd1,
        K_RD_ABS   = 4'd2,
        K_WR_ABS   = 4'd3,
        K_RD_FRM   = 4'd4,
        K_WR_FRM   = 4'd5,
        K_SETUP    = 4'd6,
        K_SET_PAR  = 4'd7,
        K_TEARDOWN = 4'd8,
        K_GET_RET  = 4'd9
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_OFFSET = 3'd1,
        ST_UNDERFLOW  = 3'd2,
        ST_TYPE       = 3'd3,
        ST_BAD_PUSH   = 3'd4,
        ST_OVERFLOW   = 3'd5,
        ST_BAD_RETURN = 3'd6,
        ST_BAD_PARAMS = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_LOOK,
        FSM_EXEC
    } fsm_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // latch the input beat
        logic top_rd;   // read the top frame entry
        logic look;     // latch top frame, issue value and caller reads
        logic commit;   // apply updates and load the result
    } cmd_t;

endpackage

// ===== hw/rtl/cfvs_ram.sv =====
// ----------------------------------------------------------------------------
// cfvs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cfvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold the last read word while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/cfvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfvs_ctrl
// Sequencer: accept a beat, look up the frame, execute, hand off the result.
// ----------------------------------------------------------------------------
module cfvs_ctrl
    import cfvs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    fsm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            FSM_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.top_rd = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = FSM_LOOK;
                end
            end
            FSM_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = FSM_EXEC;
            end
            FSM_EXEC:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result not presented after commit");

    a_look_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_LOOK |=> state_reg == FSM_EXEC)
        else $error("lookup not followed by execute");

    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == FSM_LOOK)
        else $error("accept not followed by lookup");

endmodule

// ===== hw/rtl/cfvs_dp.sv =====
// ----------------------------------------------------------------------------
// cfvs_dp
// Datapath: stack pointers, value and frame memories, checks and result.
// ----------------------------------------------------------------------------
module cfvs_dp
    import cfvs_pkg::*;
#(
    parameter int VALUE_DEPTH    = VALUE_DEPTH_DEF,
    parameter int FRAME_DEPTH    = FRAME_DEPTH_DEF,
    parameter int CODE_ADDR_BITS = CODE_ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [3:0]  kind,
    input  logic [3:0]  val_tag,
    input  logic        check_type,
    input  logic [63:0] payload,
    input  logic [16:0] offset,
    input  logic [31:0] ret_addr,
    input  logic [7:0]  param_count,
    output logic [2:0]  status,
    output logic [3:0]  out_type,
    output logic [63:0] out_payload,
    output logic [31:0] out_return_address
);

    localparam int SC_W = $clog2(VALUE_DEPTH + 1);
    localparam int SA_W = $clog2(VALUE_DEPTH);
    localparam int FC_W = $clog2(FRAME_DEPTH + 1);
    localparam int FA_W = $clog2(FRAME_DEPTH);
    localparam int CA   = CODE_ADDR_BITS;
    localparam int FR_W = SC_W + CA + 8;
    localparam int SL_W = 68;
    localparam int CW   = ((SC_W > 17) ? SC_W : 17) + 2;
    localparam int PW   = (SC_W > 8) ? SC_W : 8;

    // stack pointers
    logic [SC_W-1:0] sc_reg, sc_next;
    logic [FC_W-1:0] fc_reg, fc_next;

    // latched input beat
    logic [3:0]  kind_reg;
    logic [3:0]  vtype_reg;
    logic        check_reg;
    logic [63:0] data_reg;
    logic [16:0] off_reg;
    logic [31:0] ra_reg;
    logic [7:0]  pc_reg;

    // top frame and resolved slot index
    logic [SC_W-1:0] top_base_reg;
    logic [CA-1:0]   top_ret_reg;
    logic [7:0]      top_par_reg;
    logic [SA_W-1:0] idx_reg, idx_next;
    logic            idx_ok_reg, idx_ok_next;

    // result register
    logic [2:0]  status_reg;
    logic [3:0]  type_reg;
    logic [63:0] payload_reg;
    logic [31:0] ra_out_reg;

    // memories
    logic            sl_we, sl_re;
    logic [SA_W-1:0] sl_waddr, sl_raddr;
    logic [SL_W-1:0] sl_wdata, sl_rdata;
    logic            fr_we, fr_re;
    logic [FA_W-1:0] fr_waddr, fr_raddr;
    logic [FR_W-1:0] fr_wdata, fr_rdata;

    logic [SC_W-1:0] fr_base;
    logic [CA-1:0]   fr_ret;
    logic [7:0]      fr_par;
    logic [FC_W-1:0] fc_m1, fc_m2;
    logic [SC_W-1:0] sc_m1;

    logic signed [CW-1:0] off_s, sc_s, base_s, rel_sum;
    logic                 abs_ok, rel_ok;

    logic [63:0]     ra_wide, ret_wide;
    logic [CA-1:0]   ra_store;
    logic [31:0]     ret32;

    logic [SC_W-1:0] locals, avail, s2;
    logic [PW-1:0]   par_x, s2_x;
    logic            td_fit, has, caller_ok, avail_ok, ret_nz, type_miss;
    logic            sc_room, fr_room;

    status_t         st;
    logic [3:0]      ot;
    logic [63:0]     op;
    logic [31:0]     ora;

    assign fr_base = fr_rdata[FR_W-1 -: SC_W];
    assign fr_ret  = fr_rdata[8 +: CA];
    assign fr_par  = fr_rdata[7:0];

    assign fc_m1 = fc_reg - 1'b1;
    assign fc_m2 = fc_reg - FC_W'(2);
    assign sc_m1 = sc_reg - 1'b1;

    cfvs_ram #(.WIDTH(SL_W), .DEPTH(VALUE_DEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .re    (sl_re),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    cfvs_ram #(.WIDTH(FR_W), .DEPTH(FRAME_DEPTH)) u_frame_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .re    (fr_re),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    // top frame while idle, caller frame during lookup
    assign fr_re    = cmd.top_rd || cmd.look;
    assign fr_raddr = cmd.look ? fc_m2[FA_W-1:0] : fc_m1[FA_W-1:0];
    assign sl_re    = cmd.look;
    assign sl_raddr = idx_next;

    // lookup: resolve the slot index from the fresh top frame
    always_comb
    begin
        off_s   = $signed({{(CW-17){off_reg[16]}}, off_reg});
        sc_s    = $signed({{(CW-SC_W){1'b0}}, sc_reg});
        base_s  = $signed({{(CW-SC_W){1'b0}}, fr_base});
        rel_sum = base_s + off_s;
        abs_ok  = !off_s[CW-1] && (off_s < sc_s);
        rel_ok  = (fc_reg != '0) && !rel_sum[CW-1] && (rel_sum < sc_s);
        idx_next    = sc_m1[SA_W-1:0];
        idx_ok_next = 1'b0;
        unique case (kind_reg)
            K_PUSH:
            begin
                idx_next = sc_reg[SA_W-1:0];
            end
            K_RD_ABS, K_WR_ABS:
            begin
                idx_next    = off_s[SA_W-1:0];
                idx_ok_next = abs_ok;
            end
            K_RD_FRM, K_WR_FRM:
            begin
                idx_next    = rel_sum[SA_W-1:0];
                idx_ok_next = rel_ok;
            end
            default:
            begin
                idx_next = sc_m1[SA_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg  <= kind;
            vtype_reg <= val_tag;
            check_reg <= check_type;
            data_reg  <= payload;
            off_reg   <= offset;
            ra_reg    <= ret_addr;
            pc_reg    <= param_count;
        end
        if (cmd.look)
        begin
            top_base_reg <= fr_base;
            top_ret_reg  <= fr_ret;
            top_par_reg  <= fr_par;
            idx_reg      <= idx_next;
            idx_ok_reg   <= idx_ok_next;
        end
        if (cmd.commit)
        begin
            status_reg  <= st;
            type_reg    <= ot;
            payload_reg <= op;
            ra_out_reg  <= ora;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= '0;
            fc_reg <= '0;
        end
        else if (cmd.commit)
        begin
            sc_reg <= sc_next;
            fc_reg <= fc_next;
        end
    end

    // execute: checks and teardown arithmetic on registered operands
    always_comb
    begin
        ra_wide   = 64'(ra_reg);
        ra_store  = ra_wide[CA-1:0];
        ret_wide  = 64'(top_ret_reg);
        ret32     = ret_wide[31:0];
        type_miss = check_reg && (sl_rdata[67:64] != vtype_reg);
        sc_room   = sc_reg < SC_W'(VALUE_DEPTH);
        fr_room   = fc_reg < FC_W'(FRAME_DEPTH);
        locals    = sc_reg - top_base_reg;
        par_x     = PW'(top_par_reg);
        td_fit    = PW'(locals) >= par_x;
        has       = PW'(locals) > par_x;
        caller_ok = fc_m1 != '0;
        avail     = top_base_reg - fr_base;
        avail_ok  = PW'(avail) >= par_x;
        s2_x      = PW'(top_base_reg) - par_x;
        s2        = s2_x[SC_W-1:0];
        ret_nz    = top_ret_reg != '0;
    end

    always_comb
    begin
        st       = ST_OK;
        ot       = '0;
        op       = '0;
        ora      = '0;
        sc_next  = sc_reg;
        fc_next  = fc_reg;
        sl_we    = 1'b0;
        sl_waddr = idx_reg;
        sl_wdata = {vtype_reg, data_reg};
        fr_we    = 1'b0;
        fr_waddr = fc_reg[FA_W-1:0];
        fr_wdata = {sc_reg, ra_store, 8'd0};
        unique case (kind_reg)
            K_PUSH:
            begin
                if (fc_reg == '0)
                begin
                    st = ST_BAD_PUSH;
                end
                else if (!sc_room)
                begin
                    st = ST_OVERFLOW;
                end
                else
                begin
                    sl_we   = cmd.commit;
                    sc_next = sc_reg + 1'b1;
                end
            end
            K_POP:
            begin
                if (sc_reg == '0 || fc_reg == '0)
                begin
                    st = ST_BAD_OFFSET;
                end
                else if (sc_reg <= top_base_reg)
                begin
                    st = ST_UNDERFLOW;
                end
                else if (type_miss)
                begin
                    st = ST_TYPE;
                end
                else
                begin
                    ot      = sl_rdata[67:64];
                    op      = sl_rdata[63:0];
                    sc_next = sc_m1;
                end
            end
            K_RD_ABS, K_RD_FRM:
            begin
                if (!idx_ok_reg)
                begin
                    st = ST_BAD_OFFSET;
                end
                else if (kind_reg == K_RD_FRM && type_miss)
                begin
                    st = ST_TYPE;
                end
                else
                begin
                    ot = sl_rdata[67:64];
                    op = sl_rdata[63:0];
                end
            end
            K_WR_ABS, K_WR_FRM:
            begin
                if (!idx_ok_reg)
                begin
                    st = ST_BAD_OFFSET;
                end
                else
                begin
                    sl_we = cmd.commit;
                end
            end
            K_SETUP:
            begin
                if (!fr_room)
                begin
                    st = ST_OVERFLOW;
                end
                else
                begin
                    fr_we   = cmd.commit;
                    fc_next = fc_reg + 1'b1;
                end
            end
            K_SET_PAR:
            begin
                if (fc_reg == '0 || top_par_reg != '0)
                begin
                    st = ST_BAD_PARAMS;
                end
                else
                begin
                    fr_we    = cmd.commit;
                    fr_waddr = fc_m1[FA_W-1:0];
                    fr_wdata = {top_base_reg, top_ret_reg, pc_reg};
                end
            end
            K_TEARDOWN:
            begin
                if (fc_reg == '0)
                begin
                    st = ST_BAD_RETURN;
                end
                else if (!td_fit)
                begin
                    // parameters run out below the frame base
                    sc_next = top_base_reg;
                    st      = (top_base_reg == '0) ? ST_BAD_OFFSET : ST_UNDERFLOW;
                end
                else
                begin
                    ora     = ret32;
                    fc_next = fc_m1;
                    sc_next = top_base_reg;
                    if (ret_nz)
                    begin
                        if (top_par_reg != '0 && !caller_ok)
                        begin
                            st = ST_BAD_OFFSET;
                        end
                        else if (top_par_reg != '0 && !avail_ok)
                        begin
                            sc_next = fr_base;
                            st      = (fr_base == '0) ? ST_BAD_OFFSET : ST_UNDERFLOW;
                        end
                        else
                        begin
                            sc_next = s2;
                            if (has)
                            begin
                                if (!caller_ok)
                                begin
                                    st = ST_BAD_PUSH;
                                end
                                else
                                begin
                                    // push the return value into the caller frame
                                    sl_we    = cmd.commit;
                                    sl_waddr = s2[SA_W-1:0];
                                    sl_wdata = sl_rdata;
                                    sc_next  = s2 + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            K_GET_RET:
            begin
                if (fc_reg == '0)
                begin
                    st = ST_BAD_OFFSET;
                end
                else
                begin
                    ora = ret32;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status             = status_reg;
    assign out_type           = type_reg;
    assign out_payload        = payload_reg;
    assign out_return_address = ra_out_reg;

    a_sc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sc_reg <= SC_W'(VALUE_DEPTH))
        else $error("value count beyond depth");

    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FC_W'(FRAME_DEPTH))
        else $error("frame count beyond depth");

    a_setup_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && kind_reg == K_SETUP && st == ST_OK
        |=> fc_reg == FC_W'($past(fc_reg) + 1'b1))
        else $error("setup did not add a frame");

endmodule

// ===== hw/rtl/call_frame_value_stack.sv =====
// ----------------------------------------------------------------------------
// call_frame_value_stack
// Typed value stack with call frames: push, pop, indexed access, frame
// setup and teardown, one status result per operation.
// ----------------------------------------------------------------------------
// Each accepted operation presents one result beat: the top frame entry is
// read at the edge that takes it, the value memory and the caller frame
// entry in the lookup state, and the checks and updates happen in the
// execute state, which holds while the output register is still full. A new
// operation is taken only after the previous one has committed its result;
// the single read port of the frame memory and the registered reads of both
// memories set this sequence. The memories need no clearing after reset, so
// the block accepts operations from the first cycle after reset.
module call_frame_value_stack
    import cfvs_pkg::*;
#(
    parameter int VALUE_DEPTH    = VALUE_DEPTH_DEF,
    parameter int FRAME_DEPTH    = FRAME_DEPTH_DEF,
    parameter int CODE_ADDR_BITS = CODE_ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  kind,
    input  logic [3:0]  val_tag,
    input  logic        check_type,
    input  logic [63:0] payload,
    input  logic [16:0] offset,
    input  logic [31:0] ret_addr,
    input  logic [7:0]  param_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  out_type,
    output logic [63:0] out_payload,
    output logic [31:0] out_return_address
);

    cmd_t cmd;

    cfvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    cfvs_dp #(
        .VALUE_DEPTH    (VALUE_DEPTH),
        .FRAME_DEPTH    (FRAME_DEPTH),
        .CODE_ADDR_BITS (CODE_ADDR_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .kind               (kind),
        .val_tag            (val_tag),
        .check_type         (check_type),
        .payload            (payload),
        .offset             (offset),
        .ret_addr           (ret_addr),
        .param_count        (param_count),
        .status             (status),
        .out_type           (out_type),
        .out_payload        (out_payload),
        .out_return_address (out_return_address)
    );

endmodule
